// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on i_clk and off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define DDO_ASSERT_NEXT(lbl, pre, post, msg) \
    `DDO_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/core/ddo_pkg.sv =====
package ddo_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANG,
        ST_DIST,
        ST_STEP,
        ST_KMUL,
        ST_FOLD,
        ST_ROT,
        ST_DONE
    } t_state;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_ANGLE_GAIN    = 2'd0;
    localparam t_cfg_index CFG_DISTANCE_GAIN = 2'd1;
    localparam t_cfg_index CFG_WRAP_LIMIT    = 2'd2;

    localparam logic [15:0] ANGLE_GAIN_RST    = 16'd6489;
    localparam logic [15:0] DISTANCE_GAIN_RST = 16'd16487;
    localparam logic [14:0] WRAP_LIMIT_RST    = 15'd1000;
    localparam logic [15:0] LAST_RST          = 16'h8000;

    localparam int DELTA_W = 18;
    localparam int SUM_W   = 19;
    localparam int MA_W    = 26;
    localparam int MB_W    = 33;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int STEP_W  = 26;
    localparam int MAG_W   = 25;
    localparam int XW      = 44;
    localparam int ZW      = 33;
    localparam int DX_W    = 28;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [31:0] CORDIC_K = 32'h9B74EDA8;

    localparam logic signed [ZW-1:0] Z_QUARTER = 33'sh0_4000_0000;
    localparam logic signed [ZW-1:0] Z_HALF    = 33'sh0_8000_0000;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2FA;
            5'd15:   v = 30'h0000517D;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A30;
            5'd19:   v = 30'h00000518;
            5'd20:   v = 30'h0000028C;
            5'd21:   v = 30'h00000146;
            5'd22:   v = 30'h000000A3;
            5'd23:   v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return $signed({3'b000, v});
    endfunction

endpackage

// ===== rtl/core/differential_drive_odometry.sv =====
// Wheel-encoder odometry for a differential-drive base. Each input beat carries raw signed
// 16-bit right and left encoder counts (mode 0) or a request to start a new iteration
// (mode 1, which clears heading and travelled distance and leaves position alone). Count
// deltas are unwrapped against wrap_limit, scaled by angle_gain and distance_gain (Q8.8,
// round to nearest), and the position moves by the distance step along the new heading,
// found by a rotation-mode CORDIC. A mode 1 beat goes from acceptance straight to the
// output register. A tick uses one shared multiplier three times, for the angle, the
// distance step and the CORDIC gain, and then the CORDIC stage, which does one
// micro-rotation per cycle and then adds the rounded step to the position. One beat is
// worked on at a time; the result sits in an output register, so the next beat is
// accepted while it waits. Distance and position saturate; position is held in
// POSITION_BITS and reported clamped to 32 bits.
// Configuration writes take effect at once and belong between beats.
`include "assert_macros.svh"

module differential_drive_odometry #(
    parameter int CORDIC_STEPS  = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_in_mode,
    input  logic signed [15:0]  i_in_right_reading,
    input  logic signed [15:0]  i_in_left_reading,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_out_heading,
    output logic signed [31:0]  o_out_travelled,
    output logic signed [31:0]  o_out_position_x,
    output logic signed [31:0]  o_out_position_y
);

    localparam int NSTEP = (CORDIC_STEPS > ddo_pkg::ATAN_ENTRIES) ?
                           ddo_pkg::ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [4:0] ITER_END = 5'(NSTEP);
    localparam int PB = POSITION_BITS;
    localparam int SW = ((PB > ddo_pkg::DX_W) ? PB : ddo_pkg::DX_W) + 1;
    localparam int EW = (PB > 32) ? PB : 32;
    localparam logic signed [SW-1:0] P_MAX = {{(SW - PB + 1){1'b0}}, {(PB - 1){1'b1}}};
    localparam logic signed [SW-1:0] P_MIN = ~P_MAX;
    localparam logic signed [EW-1:0] O_MAX = EW'(2147483647);
    localparam logic signed [EW-1:0] O_MIN = -O_MAX - EW'(1);

    ddo_pkg::t_state r_state, n_state;

    logic [15:0] r_angle_gain, r_distance_gain;
    logic [14:0] r_wrap_limit;

    logic [15:0]        r_last_right, r_last_left;
    logic [15:0]        r_angle;
    logic signed [31:0] r_distance;
    logic signed [PB-1:0] r_pos_x, r_pos_y;

    logic signed [ddo_pkg::SUM_W-1:0]  r_diff, r_sum;
    logic signed [ddo_pkg::PROD_W-1:0] r_prod;
    logic [ddo_pkg::MAG_W-1:0]         r_mag;
    logic                              r_neg;
    logic signed [ddo_pkg::XW-1:0]     r_x, r_y;
    logic signed [ddo_pkg::ZW-1:0]     r_z;
    logic [4:0]                        r_iter;

    logic               r_out_valid;
    logic signed [15:0] r_out_heading;
    logic signed [31:0] r_out_travelled, r_out_x, r_out_y;

    logic in_fire, out_free;
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // encoder unwrap
    logic [15:0] enc_r, enc_l;
    logic signed [ddo_pkg::DELTA_W-1:0] d_r, d_l, raw_r, raw_l, lim;
    always_comb begin
        enc_r = {~i_in_right_reading[15], i_in_right_reading[14:0]};
        enc_l = {~i_in_left_reading[15], i_in_left_reading[14:0]};
        lim   = $signed({3'b000, r_wrap_limit});
        raw_r = $signed({2'b00, enc_r}) - $signed({2'b00, r_last_right});
        raw_l = $signed({2'b00, enc_l}) - $signed({2'b00, r_last_left});
        if (raw_r > lim) begin
            d_r = raw_r - 18'sd65536;
        end else if (raw_r < -lim) begin
            d_r = raw_r + 18'sd65536;
        end else begin
            d_r = raw_r;
        end
        if (raw_l > lim) begin
            d_l = raw_l - 18'sd65536;
        end else if (raw_l < -lim) begin
            d_l = raw_l + 18'sd65536;
        end else begin
            d_l = raw_l;
        end
    end

    // shared multiplier
    logic signed [ddo_pkg::MA_W-1:0] mul_a;
    logic signed [ddo_pkg::MB_W-1:0] mul_b;
    always_comb begin
        case (r_state)
            ddo_pkg::ST_ANG: begin
                mul_a = ddo_pkg::MA_W'(r_diff);
                mul_b = $signed({17'd0, r_angle_gain});
            end
            ddo_pkg::ST_DIST: begin
                mul_a = ddo_pkg::MA_W'(r_sum);
                mul_b = $signed({17'd0, r_distance_gain});
            end
            default: begin
                mul_a = $signed({1'b0, r_mag});
                mul_b = $signed({1'b0, ddo_pkg::CORDIC_K});
            end
        endcase
    end

    logic signed [ddo_pkg::PROD_W-1:0] prod_rnd;
    logic signed [ddo_pkg::STEP_W-1:0] step, step_abs;
    logic signed [32:0]                dist_sum;
    assign prod_rnd = r_prod + ddo_pkg::PROD_W'(128);
    assign step     = prod_rnd[ddo_pkg::STEP_W+7:8];
    assign step_abs = step[ddo_pkg::STEP_W-1] ? -step : step;
    assign dist_sum = $signed({r_distance[31], r_distance}) + 33'(step);

    // fold into the right half plane
    logic [31:0]                   z_raw;
    logic signed [ddo_pkg::ZW-1:0] z_ext;
    logic signed [ddo_pkg::XW-1:0] x_start;
    assign z_raw   = {r_angle[15] ^ r_neg, r_angle[14:0], 16'd0};
    assign z_ext   = $signed({z_raw[31], z_raw});
    assign x_start = $signed({3'b000, r_prod[56:16]});

    logic signed [ddo_pkg::XW-1:0] xs, ys;
    logic signed [ddo_pkg::ZW-1:0] atan_v;
    assign xs     = r_x >>> r_iter;
    assign ys     = r_y >>> r_iter;
    assign atan_v = ddo_pkg::atan_entry(r_iter);

    // round and accumulate position
    logic signed [ddo_pkg::XW-1:0]   x_rnd, y_rnd;
    logic signed [SW-1:0]            px_sum, py_sum;
    logic signed [PB-1:0]            px_next, py_next;
    always_comb begin
        x_rnd  = r_x + ddo_pkg::XW'(32768);
        y_rnd  = r_y + ddo_pkg::XW'(32768);
        px_sum = SW'(r_pos_x) + SW'($signed(x_rnd[ddo_pkg::XW-1:16]));
        py_sum = SW'(r_pos_y) + SW'($signed(y_rnd[ddo_pkg::XW-1:16]));
        if (px_sum > P_MAX) begin
            px_next = PB'(P_MAX);
        end else if (px_sum < P_MIN) begin
            px_next = PB'(P_MIN);
        end else begin
            px_next = PB'(px_sum);
        end
        if (py_sum > P_MAX) begin
            py_next = PB'(P_MAX);
        end else if (py_sum < P_MIN) begin
            py_next = PB'(P_MIN);
        end else begin
            py_next = PB'(py_sum);
        end
    end

    logic signed [EW-1:0] px_ext, py_ext;
    logic signed [31:0]   px_out, py_out;
    always_comb begin
        px_ext = EW'(r_pos_x);
        py_ext = EW'(r_pos_y);
        if (px_ext > O_MAX) begin
            px_out = 32'(O_MAX);
        end else if (px_ext < O_MIN) begin
            px_out = 32'(O_MIN);
        end else begin
            px_out = 32'(px_ext);
        end
        if (py_ext > O_MAX) begin
            py_out = 32'(O_MAX);
        end else if (py_ext < O_MIN) begin
            py_out = 32'(O_MIN);
        end else begin
            py_out = 32'(py_ext);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddo_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ddo_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = i_in_mode ? ddo_pkg::ST_DONE : ddo_pkg::ST_ANG;
                end
            end
            ddo_pkg::ST_ANG:  n_state = ddo_pkg::ST_DIST;
            ddo_pkg::ST_DIST: n_state = ddo_pkg::ST_STEP;
            ddo_pkg::ST_STEP: n_state = ddo_pkg::ST_KMUL;
            ddo_pkg::ST_KMUL: n_state = ddo_pkg::ST_FOLD;
            ddo_pkg::ST_FOLD: n_state = ddo_pkg::ST_ROT;
            ddo_pkg::ST_ROT: begin
                if (r_iter == ITER_END) begin
                    n_state = ddo_pkg::ST_DONE;
                end
            end
            ddo_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = ddo_pkg::ST_IDLE;
                end
            end
            default: n_state = ddo_pkg::ST_IDLE;
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_gain    <= ddo_pkg::ANGLE_GAIN_RST;
            r_distance_gain <= ddo_pkg::DISTANCE_GAIN_RST;
            r_wrap_limit    <= ddo_pkg::WRAP_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ddo_pkg::CFG_ANGLE_GAIN:    r_angle_gain    <= i_cfg_wdata;
                ddo_pkg::CFG_DISTANCE_GAIN: r_distance_gain <= i_cfg_wdata;
                ddo_pkg::CFG_WRAP_LIMIT:    r_wrap_limit    <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // odometry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_right <= ddo_pkg::LAST_RST;
            r_last_left  <= ddo_pkg::LAST_RST;
            r_angle      <= 16'd0;
            r_distance   <= 32'sd0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
        end else begin
            if (in_fire) begin
                if (i_in_mode) begin
                    r_angle    <= 16'd0;
                    r_distance <= 32'sd0;
                end else begin
                    r_last_right <= enc_r;
                    r_last_left  <= enc_l;
                end
            end
            if (r_state == ddo_pkg::ST_DIST) begin
                r_angle <= r_angle + prod_rnd[23:8];
            end
            if (r_state == ddo_pkg::ST_STEP) begin
                if (dist_sum[32] != dist_sum[31]) begin
                    r_distance <= dist_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_distance <= dist_sum[31:0];
                end
            end
            if (r_state == ddo_pkg::ST_ROT && r_iter == ITER_END) begin
                r_pos_x <= px_next;
                r_pos_y <= py_next;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) begin
            r_diff <= ddo_pkg::SUM_W'(d_r) - ddo_pkg::SUM_W'(d_l);
            r_sum  <= ddo_pkg::SUM_W'(d_r) + ddo_pkg::SUM_W'(d_l);
        end
        case (r_state)
            ddo_pkg::ST_STEP: begin
                r_mag <= step_abs[ddo_pkg::MAG_W-1:0];
                r_neg <= step[ddo_pkg::STEP_W-1];
            end
            ddo_pkg::ST_FOLD: begin
                r_y    <= '0;
                r_iter <= 5'd0;
                if (z_ext > ddo_pkg::Z_QUARTER) begin
                    r_x <= -x_start;
                    r_z <= z_ext - ddo_pkg::Z_HALF;
                end else if (z_ext < -ddo_pkg::Z_QUARTER) begin
                    r_x <= -x_start;
                    r_z <= z_ext + ddo_pkg::Z_HALF;
                end else begin
                    r_x <= x_start;
                    r_z <= z_ext;
                end
            end
            ddo_pkg::ST_ROT: begin
                r_iter <= r_iter + 5'd1;
                if (!r_z[ddo_pkg::ZW-1]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_v;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ddo_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ddo_pkg::ST_DONE && out_free) begin
            r_out_heading   <= $signed(r_angle);
            r_out_travelled <= r_distance;
            r_out_x         <= px_out;
            r_out_y         <= py_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_heading    = r_out_heading;
    assign o_out_travelled  = r_out_travelled;
    assign o_out_position_x = r_out_x;
    assign o_out_position_y = r_out_y;

    `DDO_ASSERT_NEXT(a_mode_clear_done, in_fire && i_in_mode,
        r_state == ddo_pkg::ST_DONE && r_angle == 16'd0 && r_distance == 32'sd0,
        "new iteration did not clear heading and distance")
    `DDO_ASSERT(a_iter_range, (r_state == ddo_pkg::ST_ROT) |-> (r_iter <= ITER_END),
        "cordic iteration count out of range")
    `DDO_ASSERT_NEXT(a_fold_range, r_state == ddo_pkg::ST_FOLD,
        r_z <= ddo_pkg::Z_QUARTER && r_z >= -ddo_pkg::Z_QUARTER,
        "folded angle outside right half plane")
    `DDO_ASSERT_NEXT(a_done_delivers, r_state == ddo_pkg::ST_DONE && out_free,
        o_out_valid && r_state == ddo_pkg::ST_IDLE,
        "finished beat not presented")

endmodule

// ===== tb/differential_drive_odometry_tb.sv =====
module differential_drive_odometry_tb;

    localparam int CORDIC_STEPS  = 16;
    localparam int POSITION_BITS = 32;
    localparam int ROT_ITERS     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int SETTLE_CYCLES = CORDIC_STEPS + 14;

    localparam longint GAIN_K       = 64'h9B74_EDA8;
    localparam longint QUARTER_TURN = 64'h4000_0000;
    localparam longint HALF_TURN    = 64'h8000_0000;
    localparam longint POS_MAX      = (longint'(1) <<< (POSITION_BITS - 1)) - 1;
    localparam longint POS_MIN      = -POS_MAX - 1;
    localparam longint I32_MAX      = 64'sd2147483647;
    localparam longint I32_MIN      = -64'sd2147483648;

    localparam ddo_pkg::t_cfg_index CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [31:0] travelled;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_odo_result;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_wr_en = 1'b0;
    ddo_pkg::t_cfg_index cfg_index = ddo_pkg::CFG_ANGLE_GAIN;
    logic [15:0]         cfg_wdata = 16'h0000;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                in_mode   = 1'b0;
    logic signed [15:0]  in_right  = 16'sh0000;
    logic signed [15:0]  in_left   = 16'sh0000;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [15:0]  out_heading;
    logic signed [31:0]  out_travelled;
    logic signed [31:0]  out_pos_x;
    logic signed [31:0]  out_pos_y;

    // odometry shadow state and register copies
    logic [15:0] ang_gain     = 16'd6489;
    logic [15:0] dist_gain    = 16'd16487;
    logic [14:0] wrap_lim     = 15'd1000;
    logic [15:0] last_right   = 16'h8000;
    logic [15:0] last_left    = 16'h8000;
    logic [15:0] heading_acc  = 16'h0000;
    longint      dist_acc     = 0;
    longint      x_acc        = 0;
    longint      y_acc        = 0;

    longint atan_lut [0:23] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    t_odo_result expected_results [$];
    t_odo_result oldest;
    int          fail_count = 0;
    int          stall_left = 0;
    bit          in_idle    = 1'b0;
    bit          out_idle   = 1'b0;
    logic [15:0] drv_right  = 16'h0000;
    logic [15:0] drv_left   = 16'h0000;

    differential_drive_odometry #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .POSITION_BITS (POSITION_BITS)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_wdata        (cfg_wdata),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_in_mode          (in_mode),
        .i_in_right_reading (in_right),
        .i_in_left_reading  (in_left),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_out_heading      (out_heading),
        .o_out_travelled    (out_travelled),
        .o_out_position_x   (out_pos_x),
        .o_out_position_y   (out_pos_y)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // unwrapped count delta against the rollover limit
    function automatic longint count_delta(input logic [15:0] reading, input logic [15:0] last);
        logic [15:0] enc;
        longint      d;
        longint      lim;
        enc = reading ^ 16'h8000;
        d   = longint'(enc) - longint'(last);
        lim = longint'(wrap_lim);
        if (d > lim) begin
            d = d - 65536;
        end else if (d < -lim) begin
            d = d + 65536;
        end
        return d;
    endfunction

    // q8.8 gain, round to nearest with ties upward
    function automatic longint scale_q88(input longint delta, input logic [15:0] gain);
        return (delta * longint'(gain) + 128) >>> 8;
    endfunction

    function automatic void rotate_step(input longint step, input logic [15:0] ang,
                                        output longint dx, output longint dy);
        logic [31:0] z32;
        longint      mag;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        z32 = {ang, 16'h0000};
        mag = step;
        if (mag < 0) begin
            mag = -mag;
            z32 = z32 + 32'h8000_0000;
        end
        x = (mag * GAIN_K) >>> 16;
        y = 0;
        z = longint'($signed(z32));
        if (z > QUARTER_TURN) begin
            x = -x;
            z = z - HALF_TURN;
        end else if (z < -QUARTER_TURN) begin
            x = -x;
            z = z + HALF_TURN;
        end
        for (int i = 0; i < ROT_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end
        end
        dx = (x + 32768) >>> 16;
        dy = (y + 32768) >>> 16;
    endfunction

    function automatic t_odo_result predict_tick(input logic mode, input logic [15:0] right,
                                                 input logic [15:0] left);
        longint      dr;
        longint      dl;
        longint      dang;
        longint      stp;
        longint      dx;
        longint      dy;
        t_odo_result res;
        if (mode) begin
            heading_acc = 16'h0000;
            dist_acc    = 0;
        end else begin
            dr          = count_delta(right, last_right);
            dl          = count_delta(left, last_left);
            last_right  = right ^ 16'h8000;
            last_left   = left ^ 16'h8000;
            dang        = scale_q88(dr - dl, ang_gain);
            stp         = scale_q88(dr + dl, dist_gain);
            heading_acc = heading_acc + 16'(dang);
            dist_acc    = clamp_range(dist_acc + stp, I32_MIN, I32_MAX);
            rotate_step(stp, heading_acc, dx, dy);
            x_acc = clamp_range(x_acc + dx, POS_MIN, POS_MAX);
            y_acc = clamp_range(y_acc + dy, POS_MIN, POS_MAX);
        end
        res.heading   = heading_acc;
        res.travelled = 32'(dist_acc);
        res.pos_x     = 32'(clamp_range(x_acc, I32_MIN, I32_MAX));
        res.pos_y     = 32'(clamp_range(y_acc, I32_MIN, I32_MAX));
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [15:0] wheel_move();
        int lim;
        int v;
        lim = int'(wrap_lim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 128)) - 64;
            6:                v = int'($urandom_range(0, 2 * lim)) - lim;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = lim;
                    1:       v = -lim;
                    2:       v = lim + 1;
                    default: v = -lim - 1;
                endcase
            end
            8:       v = int'($urandom);
            default: v = 0;
        endcase
        return 16'(v);
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (stall_left == 0 && out_idle) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                $display("%0t: result beat with nothing expected, heading %0d travelled %0d",
                         $time, out_heading, out_travelled);
            end else begin
                oldest = expected_results.pop_front();
                compare_field("heading", oldest.heading, out_heading);
                compare_field("travelled", oldest.travelled, out_travelled);
                compare_field("position_x", oldest.pos_x, out_pos_x);
                compare_field("position_y", oldest.pos_y, out_pos_y);
            end
        end
    end

    task automatic send_tick(input logic mode, input logic [15:0] right,
                             input logic [15:0] left);
        int gap;
        gap = in_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= mode;
        in_right <= right;
        in_left  <= left;
        do @(posedge clk); while (!in_ready);
        expected_results.push_back(predict_tick(mode, right, left));
        if (!mode) begin
            drv_right = right;
            drv_left  = left;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input ddo_pkg::t_cfg_index idx, input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            ddo_pkg::CFG_ANGLE_GAIN:    ang_gain  = value;
            ddo_pkg::CFG_DISTANCE_GAIN: dist_gain = value;
            ddo_pkg::CFG_WRAP_LIMIT:    wrap_lim  = value[14:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] a, input logic [15:0] d, input logic [15:0] w);
        write_reg(ddo_pkg::CFG_ANGLE_GAIN, a);
        write_reg(ddo_pkg::CFG_DISTANCE_GAIN, d);
        write_reg(ddo_pkg::CFG_WRAP_LIMIT, w);
    endtask

    // well-formed wheel motion with some noise and new iterations
    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_tick(1'b1, 16'($urandom), 16'($urandom));
            end else if (r < 10) begin
                send_tick(1'b0, 16'($urandom), 16'($urandom));
            end else begin
                send_tick(1'b0, drv_right + wheel_move(), drv_left + wheel_move());
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] a, input logic [15:0] d, input logic [15:0] w,
                             input int count, input bit idle_in, input bit idle_out);
        in_idle  = idle_in;
        out_idle = idle_out;
        set_config(a, d, w);
        run_random(count);
        wait_idle();
    endtask

    task automatic test_directed();
        in_idle  = 1'b0;
        out_idle = 1'b1;
        // unused index must leave the gains alone
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_tick(1'b0, 16'sd0, 16'sd0);
        send_tick(1'b0, 16'sd10, 16'sd10);
        send_tick(1'b0, 16'sd610, -16'sd590);
        send_tick(1'b0, 16'sd700, -16'sd500);
        send_tick(1'b0, 16'sd600, -16'sd600);
        // delta right at the limit, then one past it
        send_tick(1'b0, 16'sd1600, 16'sd400);
        send_tick(1'b0, 16'sd2601, 16'sd1400);
        send_tick(1'b1, 16'sh8000, 16'sh7FFF);
        send_tick(1'b0, 16'sh7FFF, 16'sh8000);
        send_tick(1'b0, 16'sh8000, 16'sh7FFF);
        send_tick(1'b0, -16'sd32767, 16'sd32766);
        send_tick(1'b1, 16'sd0, 16'sd0);
        wait_idle();
        // half-count ties
        write_reg(ddo_pkg::CFG_ANGLE_GAIN, 16'd128);
        write_reg(ddo_pkg::CFG_DISTANCE_GAIN, 16'd128);
        send_tick(1'b0, -16'sd32766, 16'sd32765);
        send_tick(1'b0, -16'sd32765, 16'sd32765);
        send_tick(1'b0, -16'sd32766, 16'sd32765);
        send_tick(1'b0, -16'sd32766, 16'sd32764);
        wait_idle();
        write_reg(ddo_pkg::CFG_WRAP_LIMIT, 16'h0000);
        send_tick(1'b0, -16'sd32767, 16'sd32764);
        send_tick(1'b0, -16'sd32767, 16'sd32765);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        run_phase(16'd6489, 16'd16487, 16'd1000, 200, 1'b1, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 16'h7FFF, 200, 1'b0, 1'b0);
        run_phase(16'h0000, 16'h0000, 16'h8000, 100, 1'b1, 1'b0);
        run_phase(16'd300, 16'd1000, 16'd1, 80, 1'b0, 1'b1);
        repeat (4) begin
            run_phase(16'($urandom), 16'($urandom), 16'($urandom), 100,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // full-scale steps drive distance and position into their clamps
    task automatic test_saturation();
        in_idle  = 1'b1;
        out_idle = 1'b1;
        set_config(16'hFFFF, 16'hFFFF, 16'h0000);
        send_tick(1'b1, 16'($urandom), 16'($urandom));
        repeat (80) send_tick(1'b0, drv_right - 16'd1, drv_left - 16'd1);
        send_tick(1'b1, 16'($urandom), 16'($urandom));
        repeat (150) send_tick(1'b0, drv_right + 16'd1, drv_left + 16'd1);
        repeat (60) send_tick(1'b0, drv_right - 16'd1, drv_left);
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_sweep();
        test_saturation();
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
